/* design/ntc_pkg.sv */
// ----------------------------------------------------------------------------
// NTC temperature package
// Shared widths, register codes, reset values, constants and beat structs.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int MV_W         = 16;
  localparam int RES_W        = 32;
  localparam int TEMP_W       = 21;
  localparam int LOG_W        = 21;
  localparam int REG_W        = 20;
  localparam int LOG_STEPS    = 16;

  localparam logic [1:0] CFG_REF  = 2'd0;
  localparam logic [1:0] CFG_BETA = 2'd1;
  localparam logic [1:0] CFG_RN   = 2'd2;
  localparam logic [1:0] CFG_RS   = 2'd3;

  localparam logic [15:0] REF_RST  = 16'd5000;
  localparam logic [15:0] BETA_RST = 16'd3850;
  localparam logic [19:0] RN_RST   = 20'd4700;
  localparam logic [19:0] RS_RST   = 20'd10000;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_ZERO = 2'd1;
  localparam status_t ST_SAT  = 2'd2;

  localparam logic [14:0]        T0_CK       = 15'd29815;
  localparam logic [22:0]        Q16_X100    = 23'd6553600;
  localparam logic [31:0]        LN2_Q32     = 32'd2977044472;
  localparam logic signed [20:0] ZERO_CK_NEG = -21'sd27315;
  localparam logic signed [20:0] TEMP_MAX    = 21'sd1000000;

  typedef struct packed {
    logic [15:0] mv;
    status_t     cls;
  } res_side_t;

  typedef struct packed {
    logic [15:0] mv;
    logic [31:0] res;
    status_t     st;
    logic        fix;
  } log_side_t;

  typedef struct packed {
    logic [15:0] mv;
    logic [31:0] res;
    status_t     st;
    logic        fix;
    logic        dpos;
  } tmp_side_t;

endpackage

/* design/ntc_div.sv */
// ----------------------------------------------------------------------------
// NTC pipelined divider
// Restoring unsigned division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ntc_div
  import ntc_pkg::*;
#(
  parameter int NW = 36,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  logic          v_r      [NW];
  logic [NW-1:0] num_r    [NW];
  logic [NW-1:0] num_nxt  [NW];
  logic [DW-1:0] rem_r    [NW];
  logic [DW-1:0] rem_nxt  [NW];
  logic [DW-1:0] den_r    [NW];
  logic [SW-1:0] side_r   [NW];

  always_comb begin
    logic [NW-1:0] pn;
    logic [DW-1:0] pr;
    logic [DW-1:0] pd;
    logic [DW:0]   top;
    logic [DW:0]   dif;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        pn = in_num;
        pr = '0;
        pd = in_den;
      end else begin
        pn = num_r[k-1];
        pr = rem_r[k-1];
        pd = den_r[k-1];
      end
      top = {pr, pn[NW-1]};
      dif = top - {1'b0, pd};
      if (top >= {1'b0, pd}) begin
        rem_nxt[k] = dif[DW-1:0];
        num_nxt[k] = {pn[NW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = top[DW-1:0];
        num_nxt[k] = {pn[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NW; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NW; k++) v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        num_r[k]  <= num_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        den_r[k]  <= (k == 0) ? in_den : den_r[k-1];
        side_r[k] <= (k == 0) ? in_side : side_r[k-1];
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quot  = num_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

/* design/ntc_log.sv */
// ----------------------------------------------------------------------------
// NTC pipelined log2
// Two-lane log2 in Q16: normalize stage, then one squaring stage per bit.
// ----------------------------------------------------------------------------
module ntc_log
  import ntc_pkg::*;
#(
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [31:0]      in_a,
  input  logic [31:0]      in_b,
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  output logic [LOG_W-1:0] out_la,
  output logic [LOG_W-1:0] out_lb,
  output logic [SW-1:0]    out_side
);

  localparam int NS = LOG_STEPS + 1;

  function automatic logic [4:0] msb_pos(input logic [31:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 1; i < 32; i++) if (x[i]) p = 5'(i);
    return p;
  endfunction

  function automatic logic [30:0] norm(input logic [31:0] x, input logic [4:0] e);
    logic [31:0] sh;
    sh = x << (5'd30 - e);
    return (e == 5'd31) ? x[31:1] : sh[30:0];
  endfunction

  function automatic logic [31:0] sq_step(input logic [30:0] y);
    logic [61:0] p;
    logic [31:0] t;
    p = 62'(y) * 62'(y);
    t = p[61:30];
    return t[31] ? {1'b1, t[31:1]} : {1'b0, t[30:0]};
  endfunction

  logic          v_r    [NS];
  logic [SW-1:0] side_r [NS];
  logic [30:0]   y_r    [NS][2];
  logic [30:0]   y_nxt  [NS][2];
  logic [4:0]    e_r    [NS][2];
  logic [4:0]    e_nxt  [NS][2];
  logic [15:0]   f_r    [NS][2];
  logic [15:0]   f_nxt  [NS][2];

  always_comb begin
    logic [31:0] x;
    logic [31:0] s;
    for (int l = 0; l < 2; l++) begin
      x = (l == 0) ? in_a : in_b;
      if (x == '0) x = 32'd1;
      e_nxt[0][l] = msb_pos(x);
      y_nxt[0][l] = norm(x, e_nxt[0][l]);
      f_nxt[0][l] = '0;
      for (int k = 1; k < NS; k++) begin
        s           = sq_step(y_r[k-1][l]);
        y_nxt[k][l] = s[30:0];
        e_nxt[k][l] = e_r[k-1][l];
        f_nxt[k][l] = {f_r[k-1][l][14:0], s[31]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NS; k++) v_r[k] <= (k == 0) ? in_valid : v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        side_r[k] <= (k == 0) ? in_side : side_r[k-1];
        for (int l = 0; l < 2; l++) begin
          y_r[k][l] <= y_nxt[k][l];
          e_r[k][l] <= e_nxt[k][l];
          f_r[k][l] <= f_nxt[k][l];
        end
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_la    = {e_r[NS-1][0], f_r[NS-1][0]};
  assign out_lb    = {e_r[NS-1][1], f_r[NS-1][1]};
  assign out_side  = side_r[NS-1];

endmodule

/* design/ntc_adc_to_temperature_unit.sv */
// ----------------------------------------------------------------------------
// NTC ADC to temperature unit
// Converts a thermistor divider sample to millivolts, ohms and centi-degC.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while not stalled; the 36-stage resistance
// divider and 55-stage temperature divider each take one bit per stage, and the
// 17-stage log2 pipeline normalizes and then takes one bit per stage.
// A stall on out_ready freezes the whole pipeline in place.
// Reset clears all valid bits and loads the register reset values.
module ntc_adc_to_temperature_unit
  import ntc_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ADC_BITS-1:0]      in_adc_code,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MV_W-1:0]          out_millivolts,
  output logic [RES_W-1:0]         out_resistance_ohm,
  output logic signed [TEMP_W-1:0] out_temperature_centi_c,
  output logic [1:0]               out_status,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [REG_W-1:0]         cfg_wdata
);

  localparam int PW = ADC_BITS + 16;

  logic [15:0] ref_r, beta_r;
  logic [19:0] rn_r, rs_r;
  logic        en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r  <= REF_RST;
      beta_r <= BETA_RST;
      rn_r   <= RN_RST;
      rs_r   <= RS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REF:  ref_r  <= cfg_wdata[15:0];
        CFG_BETA: beta_r <= cfg_wdata[15:0];
        CFG_RN:   rn_r   <= cfg_wdata;
        CFG_RS:   rs_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage A: scale
  logic          a_v_r;
  logic [PW-1:0] a_prod_r;

  // stage B: classify, numerator and denominator
  logic        b_v_r;
  logic [35:0] b_num_r;
  logic [15:0] b_den_r;
  res_side_t   b_side_r;
  logic [15:0] b_mv;
  res_side_t   b_side_nxt;

  assign b_mv = a_prod_r[ADC_BITS +: 16];

  always_comb begin
    b_side_nxt.mv = b_mv;
    if (b_mv >= ref_r)    b_side_nxt.cls = ST_SAT;
    else if (b_mv == '0)  b_side_nxt.cls = ST_ZERO;
    else                  b_side_nxt.cls = ST_OK;
  end

  logic        d1_v;
  logic [35:0] d1_q;
  res_side_t   d1_side;

  ntc_div #(.NW(36), .DW(16), .SW($bits(res_side_t))) u_div_res (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (b_v_r),
    .in_num   (b_num_r),
    .in_den   (b_den_r),
    .in_side  (b_side_r),
    .out_valid(d1_v),
    .out_quot (d1_q),
    .out_side (d1_side)
  );

  // stage C: saturate resistance
  logic      c_v_r;
  log_side_t c_side_r;
  log_side_t c_side_nxt;
  logic      c_ovf;

  assign c_ovf = |d1_q[35:32];

  always_comb begin
    c_side_nxt.mv = d1_side.mv;
    if (d1_side.cls == ST_SAT) begin
      c_side_nxt.res = '1;
      c_side_nxt.st  = ST_SAT;
      c_side_nxt.fix = 1'b1;
    end else if (d1_side.cls == ST_ZERO) begin
      c_side_nxt.res = '0;
      c_side_nxt.st  = ST_ZERO;
      c_side_nxt.fix = 1'b1;
    end else begin
      c_side_nxt.res = c_ovf ? '1 : d1_q[31:0];
      if (!c_ovf && d1_q[31:0] == '0) begin
        c_side_nxt.st  = ST_ZERO;
        c_side_nxt.fix = 1'b1;
      end else begin
        c_side_nxt.st  = c_ovf ? ST_SAT : ST_OK;
        c_side_nxt.fix = 1'b0;
      end
    end
  end

  logic             lg_v;
  logic [LOG_W-1:0] lg_la, lg_lb;
  log_side_t        lg_side;
  logic [31:0]      rn_eff;

  assign rn_eff = (rn_r == '0) ? 32'd1 : 32'(rn_r);

  ntc_log #(.SW($bits(log_side_t))) u_log (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (c_v_r),
    .in_a     (c_side_r.res),
    .in_b     (rn_eff),
    .in_side  (c_side_r),
    .out_valid(lg_v),
    .out_la   (lg_la),
    .out_lb   (lg_lb),
    .out_side (lg_side)
  );

  // stage D: |L| * ln2
  logic        d_v_r, d_neg_r;
  logic [52:0] d_prod_r;
  log_side_t   d_side_r;
  logic signed [21:0] l_dif;
  logic [20:0] l_mag;

  assign l_dif = {1'b0, lg_la} - {1'b0, lg_lb};
  assign l_mag = l_dif[21] ? 21'(-l_dif) : l_dif[20:0];

  // stage E: round to Q16 ln
  logic               e_v_r;
  logic signed [21:0] e_lnq_r;
  log_side_t          e_side_r;
  logic [52:0]        e_sum;
  logic [21:0]        e_mag;

  assign e_sum = d_prod_r + 53'h0_8000_0000;
  assign e_mag = {1'b0, e_sum[52:32]};

  // stage F: ln * T0 and beta * T0
  logic               f_v_r;
  logic signed [36:0] f_t1_r;
  logic [30:0]        f_bk_r;
  log_side_t          f_side_r;

  // stage G: numerator and denominator of the beta equation
  logic               g_v_r;
  logic signed [40:0] g_d_r;
  logic [53:0]        g_n_r;
  log_side_t          g_side_r;
  logic [38:0]        g_bq;

  assign g_bq = 39'(beta_r) * 39'(Q16_X100);

  // stage H: add half denominator
  logic        h_v_r;
  logic [54:0] h_s_r;
  logic [39:0] h_den_r;
  tmp_side_t   h_side_r;
  tmp_side_t   h_side_nxt;

  always_comb begin
    h_side_nxt.mv   = g_side_r.mv;
    h_side_nxt.res  = g_side_r.res;
    h_side_nxt.st   = g_side_r.st;
    h_side_nxt.fix  = g_side_r.fix;
    h_side_nxt.dpos = !g_d_r[40] && (g_d_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= d1_v;
      d_v_r <= lg_v;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
      g_v_r <= f_v_r;
      h_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod_r <= PW'(in_adc_code) * PW'(ref_r);
      b_num_r  <= 36'(rs_r) * 36'(b_mv);
      b_den_r  <= ref_r - b_mv;
      b_side_r <= b_side_nxt;
      c_side_r <= c_side_nxt;
      d_prod_r <= 53'(l_mag) * 53'(LN2_Q32);
      d_neg_r  <= l_dif[21];
      d_side_r <= lg_side;
      e_lnq_r  <= d_neg_r ? -$signed(e_mag) : $signed(e_mag);
      e_side_r <= d_side_r;
      f_t1_r   <= 37'(e_lnq_r) * 37'($signed({1'b0, T0_CK}));
      f_bk_r   <= 31'(beta_r) * 31'(T0_CK);
      f_side_r <= e_side_r;
      g_d_r    <= 41'(f_t1_r) + $signed({2'b00, g_bq});
      g_n_r    <= 54'(f_bk_r) * 54'(Q16_X100);
      g_side_r <= f_side_r;
      h_s_r    <= 55'(g_n_r) + 55'(g_d_r[40:1]);
      h_den_r  <= g_d_r[39:0];
      h_side_r <= h_side_nxt;
    end
  end

  logic        d2_v;
  logic [54:0] d2_q;
  tmp_side_t   d2_side;

  ntc_div #(.NW(55), .DW(40), .SW($bits(tmp_side_t))) u_div_tmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (h_v_r),
    .in_num   (h_s_r),
    .in_den   (h_den_r),
    .in_side  (h_side_r),
    .out_valid(d2_v),
    .out_quot (d2_q),
    .out_side (d2_side)
  );

  // output stage: offset to Celsius and saturate
  logic signed [56:0]       t_q;
  logic signed [TEMP_W-1:0] t_nxt;
  status_t                  st_nxt;
  logic                     out_valid_r;
  logic [MV_W-1:0]          out_mv_r;
  logic [RES_W-1:0]         out_res_r;
  logic signed [TEMP_W-1:0] out_temp_r;
  status_t                  out_st_r;

  assign t_q = $signed({2'b00, d2_q}) - 57'sd27315;

  always_comb begin
    if (d2_side.fix) begin
      t_nxt  = ZERO_CK_NEG;
      st_nxt = d2_side.st;
    end else if (!d2_side.dpos || t_q > 57'(TEMP_MAX)) begin
      t_nxt  = TEMP_MAX;
      st_nxt = ST_SAT;
    end else begin
      t_nxt  = t_q[TEMP_W-1:0];
      st_nxt = d2_side.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= d2_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mv_r   <= d2_side.mv;
      out_res_r  <= d2_side.res;
      out_temp_r <= t_nxt;
      out_st_r   <= st_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_millivolts          = out_mv_r;
  assign out_resistance_ohm      = out_res_r;
  assign out_temperature_centi_c = out_temp_r;
  assign out_status              = out_st_r;

endmodule

/* design/ntc_chk.sv */
// ----------------------------------------------------------------------------
// NTC port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module ntc_chk
  import ntc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [MV_W-1:0]          out_millivolts,
  input logic [RES_W-1:0]         out_resistance_ohm,
  input logic signed [TEMP_W-1:0] out_temperature_centi_c,
  input logic [1:0]               out_status
);

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temperature_centi_c)
      && $stable(out_resistance_ohm) && $stable(out_status))
    else $error("stalled beat changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_zero_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ZERO |-> out_temperature_centi_c == ZERO_CK_NEG)
    else $error("zero resistance without absolute-zero temperature");

  a_zero_mv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_millivolts == '0 |-> out_status != ST_OK)
    else $error("zero millivolts reported ok");

endmodule

bind ntc_adc_to_temperature_unit ntc_chk u_ntc_chk (.*);
